// ===== rtl/scd_pkg.sv =====
// Shared types, scan code constants and layout tables for the scan code decoder.
package scd_pkg;

  localparam logic [7:0] BYTE_PREFIX_E0 = 8'hE0;
  localparam logic [7:0] BYTE_PREFIX_E1 = 8'hE1;

  localparam logic [6:0] KEY_SHIFT_L  = 7'd42;
  localparam logic [6:0] KEY_SHIFT_R  = 7'd54;
  localparam logic [6:0] KEY_ALT      = 7'd56;
  localparam logic [6:0] KEY_CTRL     = 7'd29;
  localparam logic [6:0] KEY_CAPS     = 7'd58;
  localparam logic [6:0] KEY_SCROLL   = 7'd70;
  localparam logic [6:0] KEY_NUM      = 7'd69;
  localparam logic [6:0] KEY_DIVIDE   = 7'd53;
  localparam logic [6:0] KEY_PAD_LO   = 7'd71;
  localparam logic [6:0] KEY_PAD_HI   = 7'd83;
  localparam logic [6:0] SCAN_DIVIDE  = 7'd8;
  localparam logic [7:0] ASCII_SLASH  = 8'd47;

  typedef enum logic [2:0] {
    PFX_NONE = 3'b001,
    PFX_E0   = 3'b010,
    PFX_E1   = 3'b100
  } prefix_t;

  typedef struct packed {
    logic shift;
    logic alt_l;
    logic alt_r;
    logic ctrl_l;
    logic ctrl_r;
  } mods_t;

  typedef struct packed {
    logic caps;
    logic num;
    logic scroll;
  } locks_t;

  typedef struct packed {
    prefix_t prefix;
    mods_t   mods;
    locks_t  locks;
  } scd_state_t;

  typedef struct packed {
    logic       key_valid;
    logic [7:0] ascii_char;
    logic [6:0] key_scan;
    mods_t      mods;
    locks_t     locks;
    logic       led_change;
  } key_result_t;

  function automatic logic is_letter(input logic [6:0] code);
    is_letter = (code inside {[7'd16:7'd26], [7'd30:7'd40], [7'd44:7'd50]});
  endfunction

  function automatic logic [7:0] tab_plain(input logic [6:0] code);
    case (code)
      7'd2: tab_plain = 8'd49;   7'd3: tab_plain = 8'd50;   7'd4: tab_plain = 8'd51;
      7'd5: tab_plain = 8'd52;   7'd6: tab_plain = 8'd53;   7'd7: tab_plain = 8'd54;
      7'd8: tab_plain = 8'd55;   7'd9: tab_plain = 8'd56;   7'd10: tab_plain = 8'd57;
      7'd11: tab_plain = 8'd48;  7'd12: tab_plain = 8'd225; 7'd13: tab_plain = 8'd39;
      7'd14: tab_plain = 8'd8;
      7'd16: tab_plain = 8'd113; 7'd17: tab_plain = 8'd119; 7'd18: tab_plain = 8'd101;
      7'd19: tab_plain = 8'd114; 7'd20: tab_plain = 8'd116; 7'd21: tab_plain = 8'd122;
      7'd22: tab_plain = 8'd117; 7'd23: tab_plain = 8'd105; 7'd24: tab_plain = 8'd111;
      7'd25: tab_plain = 8'd112; 7'd26: tab_plain = 8'd129; 7'd27: tab_plain = 8'd43;
      7'd28: tab_plain = 8'd10;
      7'd30: tab_plain = 8'd97;  7'd31: tab_plain = 8'd115; 7'd32: tab_plain = 8'd100;
      7'd33: tab_plain = 8'd102; 7'd34: tab_plain = 8'd103; 7'd35: tab_plain = 8'd104;
      7'd36: tab_plain = 8'd106; 7'd37: tab_plain = 8'd107; 7'd38: tab_plain = 8'd108;
      7'd39: tab_plain = 8'd148; 7'd40: tab_plain = 8'd132; 7'd41: tab_plain = 8'd94;
      7'd43: tab_plain = 8'd35;
      7'd44: tab_plain = 8'd121; 7'd45: tab_plain = 8'd120; 7'd46: tab_plain = 8'd99;
      7'd47: tab_plain = 8'd118; 7'd48: tab_plain = 8'd98;  7'd49: tab_plain = 8'd110;
      7'd50: tab_plain = 8'd109; 7'd51: tab_plain = 8'd44;  7'd52: tab_plain = 8'd46;
      7'd53: tab_plain = 8'd45;  7'd55: tab_plain = 8'd42;  7'd57: tab_plain = 8'd32;
      7'd74: tab_plain = 8'd45;  7'd78: tab_plain = 8'd43;  7'd86: tab_plain = 8'd60;
      default: tab_plain = 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] tab_upper(input logic [6:0] code);
    case (code)
      7'd2: tab_upper = 8'd33;   7'd3: tab_upper = 8'd34;   7'd4: tab_upper = 8'd21;
      7'd5: tab_upper = 8'd36;   7'd6: tab_upper = 8'd37;   7'd7: tab_upper = 8'd38;
      7'd8: tab_upper = 8'd47;   7'd9: tab_upper = 8'd40;   7'd10: tab_upper = 8'd41;
      7'd11: tab_upper = 8'd61;  7'd12: tab_upper = 8'd63;  7'd13: tab_upper = 8'd96;
      7'd16: tab_upper = 8'd81;  7'd17: tab_upper = 8'd87;  7'd18: tab_upper = 8'd69;
      7'd19: tab_upper = 8'd82;  7'd20: tab_upper = 8'd84;  7'd21: tab_upper = 8'd90;
      7'd22: tab_upper = 8'd85;  7'd23: tab_upper = 8'd73;  7'd24: tab_upper = 8'd79;
      7'd25: tab_upper = 8'd80;  7'd26: tab_upper = 8'd154; 7'd27: tab_upper = 8'd42;
      7'd30: tab_upper = 8'd65;  7'd31: tab_upper = 8'd83;  7'd32: tab_upper = 8'd68;
      7'd33: tab_upper = 8'd70;  7'd34: tab_upper = 8'd71;  7'd35: tab_upper = 8'd72;
      7'd36: tab_upper = 8'd74;  7'd37: tab_upper = 8'd75;  7'd38: tab_upper = 8'd76;
      7'd39: tab_upper = 8'd153; 7'd40: tab_upper = 8'd142; 7'd41: tab_upper = 8'd248;
      7'd43: tab_upper = 8'd39;
      7'd44: tab_upper = 8'd89;  7'd45: tab_upper = 8'd88;  7'd46: tab_upper = 8'd67;
      7'd47: tab_upper = 8'd86;  7'd48: tab_upper = 8'd66;  7'd49: tab_upper = 8'd78;
      7'd50: tab_upper = 8'd77;  7'd51: tab_upper = 8'd59;  7'd52: tab_upper = 8'd58;
      7'd53: tab_upper = 8'd95;  7'd57: tab_upper = 8'd32;  7'd86: tab_upper = 8'd62;
      default: tab_upper = 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] tab_altgr(input logic [6:0] code);
    case (code)
      7'd3: tab_altgr = 8'd253;  7'd8: tab_altgr = 8'd123;  7'd9: tab_altgr = 8'd91;
      7'd10: tab_altgr = 8'd93;  7'd11: tab_altgr = 8'd125; 7'd12: tab_altgr = 8'd92;
      7'd16: tab_altgr = 8'd64;  7'd27: tab_altgr = 8'd126; 7'd50: tab_altgr = 8'd230;
      7'd86: tab_altgr = 8'd124;
      default: tab_altgr = 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] pad_ascii(input logic [6:0] code);
    case (code)
      7'd71: pad_ascii = 8'd55;  7'd72: pad_ascii = 8'd56;  7'd73: pad_ascii = 8'd57;
      7'd74: pad_ascii = 8'd45;  7'd75: pad_ascii = 8'd52;  7'd76: pad_ascii = 8'd53;
      7'd77: pad_ascii = 8'd54;  7'd78: pad_ascii = 8'd43;  7'd79: pad_ascii = 8'd49;
      7'd80: pad_ascii = 8'd50;  7'd81: pad_ascii = 8'd51;  7'd82: pad_ascii = 8'd48;
      7'd83: pad_ascii = 8'd44;
      default: pad_ascii = 8'd0;
    endcase
  endfunction

  function automatic logic [6:0] pad_scan(input logic [6:0] code);
    case (code)
      7'd71: pad_scan = 7'd8;    7'd72: pad_scan = 7'd9;    7'd73: pad_scan = 7'd10;
      7'd74: pad_scan = 7'd53;   7'd75: pad_scan = 7'd5;    7'd76: pad_scan = 7'd6;
      7'd77: pad_scan = 7'd7;    7'd78: pad_scan = 7'd27;   7'd79: pad_scan = 7'd2;
      7'd80: pad_scan = 7'd3;    7'd81: pad_scan = 7'd4;    7'd82: pad_scan = 7'd11;
      7'd83: pad_scan = 7'd51;
      default: pad_scan = 7'd0;
    endcase
  endfunction

endpackage

// ===== rtl/scd_if.sv =====
// Valid/ready channel interfaces for scan bytes in and decoded keys out.
interface scd_scan_if;
  logic       valid;
  logic       ready;
  logic [7:0] scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink (input valid, input scan_byte, output ready);
endinterface

interface scd_key_if;
  logic       valid;
  logic       ready;
  logic       key_valid;
  logic [7:0] ascii_char;
  logic [6:0] key_scan;
  logic       shift_held;
  logic       alt_left_held;
  logic       alt_right_held;
  logic       ctrl_left_held;
  logic       ctrl_right_held;
  logic       caps_on;
  logic       num_on;
  logic       scroll_on;
  logic       led_change;

  modport source (output valid, output key_valid, output ascii_char, output key_scan,
                  output shift_held, output alt_left_held, output alt_right_held,
                  output ctrl_left_held, output ctrl_right_held, output caps_on,
                  output num_on, output scroll_on, output led_change, input ready);
  modport sink (input valid, input key_valid, input ascii_char, input key_scan,
                input shift_held, input alt_left_held, input alt_right_held,
                input ctrl_left_held, input ctrl_right_held, input caps_on,
                input num_on, input scroll_on, input led_change, output ready);
endinterface

// ===== rtl/scd_decode.sv =====
// Combinational decode of one scan byte against the current prefix, modifier and lock state.
module scd_decode
  import scd_pkg::*;
(
  input  logic [7:0]  scan_byte,
  input  scd_state_t  cur,
  output scd_state_t  nxt,
  output key_result_t res
);

  logic [6:0] code;
  logic       right;
  logic       valid;
  logic       led;
  logic [7:0] asc;
  logic [6:0] scn;

  assign code  = scan_byte[6:0];
  assign right = (cur.prefix == PFX_E0);

  always_comb begin
    nxt   = cur;
    valid = 1'b0;
    led   = 1'b0;
    asc   = 8'd0;
    scn   = 7'd0;
    if (scan_byte == BYTE_PREFIX_E0) begin
      nxt.prefix = PFX_E0;
    end else if (scan_byte == BYTE_PREFIX_E1) begin
      nxt.prefix = PFX_E1;
    end else if (scan_byte[7]) begin
      // Releases only matter for modifiers; any other release is dropped.
      if (code == KEY_SHIFT_L || code == KEY_SHIFT_R) begin
        nxt.mods.shift = 1'b0;
      end else if (code == KEY_ALT) begin
        if (right) nxt.mods.alt_r = 1'b0;
        else nxt.mods.alt_l = 1'b0;
      end else if (code == KEY_CTRL) begin
        if (right) nxt.mods.ctrl_r = 1'b0;
        else nxt.mods.ctrl_l = 1'b0;
      end
      nxt.prefix = PFX_NONE;
    end else begin
      if (code == KEY_SHIFT_L || code == KEY_SHIFT_R) begin
        nxt.mods.shift = 1'b1;
      end else if (code == KEY_ALT) begin
        if (right) nxt.mods.alt_r = 1'b1;
        else nxt.mods.alt_l = 1'b1;
      end else if (code == KEY_CTRL) begin
        if (right) nxt.mods.ctrl_r = 1'b1;
        else nxt.mods.ctrl_l = 1'b1;
      end else if (code == KEY_CAPS) begin
        nxt.locks.caps = ~cur.locks.caps;
        led = 1'b1;
      end else if (code == KEY_SCROLL) begin
        nxt.locks.scroll = ~cur.locks.scroll;
        led = 1'b1;
      end else if (code == KEY_NUM && !cur.mods.ctrl_l) begin
        nxt.locks.num = ~cur.locks.num;
        led = 1'b1;
      end else begin
        // Any other make code, including pause with left ctrl, is reported as a key.
        valid = 1'b1;
        scn   = code;
        if (code == KEY_DIVIDE && right) begin
          asc = ASCII_SLASH;
          scn = SCAN_DIVIDE;
        end else if (cur.locks.num && cur.prefix == PFX_NONE &&
                     code inside {[KEY_PAD_LO:KEY_PAD_HI]}) begin
          asc = pad_ascii(code);
          scn = pad_scan(code);
        end else if (cur.mods.alt_r) begin
          asc = tab_altgr(code);
        end else if (cur.mods.shift) begin
          asc = tab_upper(code);
        end else if (cur.locks.caps && is_letter(code)) begin
          asc = tab_upper(code);
        end else begin
          asc = tab_plain(code);
        end
      end
      nxt.prefix = PFX_NONE;
    end
  end

  always_comb begin
    res.key_valid  = valid;
    res.ascii_char = asc;
    res.key_scan   = scn;
    res.mods       = nxt.mods;
    res.locks      = nxt.locks;
    res.led_change = led;
  end

endmodule

// ===== rtl/scancode_to_ascii_decoder_unit.sv =====
// Top level of the set-1 scan code decoder with German layout tables.
// Each accepted scan byte produces exactly one result transfer after it has passed through
// the input register and then the result register. A new byte can be taken in every cycle
// while the sink keeps up, so the sustained rate is one byte per cycle; the only loop is
// the update of the prefix, modifier and lock registers. While a result waits for its
// sink, the input register takes at most one more byte and the input then stalls until
// the result is taken. key_valid, ascii_char and key_scan are zero for bytes that decode
// no key; the modifier and lock outputs always show the state after the byte, and
// led_change marks a lock toggle.
module scancode_to_ascii_decoder_unit
  import scd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  scd_scan_if.sink   scan_in,
  scd_key_if.source  key_out
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        out_valid;
  key_result_t out_data;
  scd_state_t  state;
  scd_state_t  state_next;
  key_result_t result;
  logic        advance;

  assign advance       = in_valid && (!out_valid || key_out.ready);
  assign scan_in.ready = !in_valid || advance;

  scd_decode u_decode (
    .scan_byte (in_byte),
    .cur       (state),
    .nxt       (state_next),
    .res       (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (scan_in.ready) begin
      in_valid <= scan_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_in.valid && scan_in.ready) begin
      in_byte <= scan_in.scan_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{prefix: PFX_NONE, mods: '0, locks: '0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (key_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  assign key_out.valid           = out_valid;
  assign key_out.key_valid       = out_data.key_valid;
  assign key_out.ascii_char      = out_data.ascii_char;
  assign key_out.key_scan        = out_data.key_scan;
  assign key_out.shift_held      = out_data.mods.shift;
  assign key_out.alt_left_held   = out_data.mods.alt_l;
  assign key_out.alt_right_held  = out_data.mods.alt_r;
  assign key_out.ctrl_left_held  = out_data.mods.ctrl_l;
  assign key_out.ctrl_right_held = out_data.mods.ctrl_r;
  assign key_out.caps_on         = out_data.locks.caps;
  assign key_out.num_on          = out_data.locks.num;
  assign key_out.scroll_on       = out_data.locks.scroll;
  assign key_out.led_change      = out_data.led_change;

`ifndef SYNTHESIS
  // A decoded key and a lock toggle never come from the same byte.
  a_key_not_led: assert property (@(posedge clk) disable iff (rst)
    out_valid && key_out.key_valid |-> !key_out.led_change)
    else $error("key result also flags an LED change");

  // Without a decoded key the character and scan fields are cleared.
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_out.key_valid |-> key_out.ascii_char == 8'd0 && key_out.key_scan == 7'd0)
    else $error("non-key result carries character or scan data");

  // A prefix lasts for one byte only.
  a_prefix_cleared: assert property (@(posedge clk) disable iff (rst)
    advance && in_byte != BYTE_PREFIX_E0 && in_byte != BYTE_PREFIX_E1
    |=> state.prefix == PFX_NONE)
    else $error("prefix survived a non-prefix byte");

  // Lock flags move only when a byte is decoded.
  a_locks_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state.locks))
    else $error("lock flags changed without a decoded byte");

  // The output register only loads while it is free or being drained.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_out.ready |-> !advance)
    else $error("pending result overwritten");
`endif

endmodule
